// ----- rtl/ucsl_pkg.sv -----
// Shared types, codes and constants of the UART command shift loader.
package ucsl_pkg;

    localparam int SHIFT_BITS = 31;
    localparam int CNT_W      = $clog2(SHIFT_BITS + 1);

    localparam logic [7:0] MAGIC_RESET = 8'hAB;

    localparam logic [7:0] CMD_LOAD = 8'd1;
    localparam logic [7:0] CMD_PIN  = 8'd2;
    localparam logic [7:0] CMD_CAL  = 8'd3;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic [1:0] ACT_PULSE  = 2'd0;
    localparam logic [1:0] ACT_PIN    = 2'd1;
    localparam logic [1:0] ACT_STATUS = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_BAD_MAG = 2'd1;
    localparam logic [1:0] STAT_BAD_CMD = 2'd2;
    localparam logic [1:0] STAT_CAL     = 2'd3;

    localparam logic [1:0] LAST_BYTE = 2'd3;

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_CMD  = 5'b00010,
        PH_DATA = 5'b00100,
        PH_IO   = 5'b01000,
        PH_CAL  = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        SEQ_IDLE  = 2'b01,
        SEQ_SHIFT = 2'b10
    } seq_t;

    typedef struct packed {
        logic [1:0] action;
        logic       data_bit;
        logic [3:0] pin_number;
        logic [3:0] pin_value;
        logic [1:0] status;
        logic       last;
    } res_t;

    function automatic res_t make_res(logic [1:0] action, logic data_bit,
                                      logic [3:0] pin_number, logic [3:0] pin_value,
                                      logic [1:0] status, logic last);
        res_t r;
        r.action     = action;
        r.data_bit   = data_bit;
        r.pin_number = pin_number;
        r.pin_value  = pin_value;
        r.status     = status;
        r.last       = last;
        return r;
    endfunction

endpackage

// ----- rtl/uart_command_shift_loader_core.sv -----
// Top level: command frame parser with a shared shift sequencer for the bit pulses.
// The first result of a transaction is registered and shows in the cycle after acceptance.
// A load gives SHIFT_BITS pulses, the first from the parser, the rest from a shared
// shift register, one per cycle while the output is read; the input is not ready
// until the last is issued. A low calibration tick gives two pulses, others at most
// one result; an unread result stalls the next transaction. Reset (aresetn
// low, synchronous) clears parser, sequencer, output valid; magic goes to MAGIC_RESET.
module uart_command_shift_loader_core
    import ucsl_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_req_type,
    input  logic [7:0] s_rx_byte,
    input  logic       s_ready_level,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_action,
    output logic       m_data_bit,
    output logic [3:0] m_pin_number,
    output logic [3:0] m_pin_value,
    output logic [1:0] m_status,
    output logic       m_last
);

    logic [7:0]            magic_reg, magic_next;
    phase_t                phase_reg, phase_next;
    seq_t                  seq_reg, seq_next;
    logic [1:0]            byte_cnt_reg, byte_cnt_next;
    logic [31:0]           asm_reg, asm_next;
    logic [SHIFT_BITS-1:0] shift_reg, shift_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  m_valid_reg, m_valid_next;
    res_t                  res_reg, res_next;

    logic        out_free;
    logic        s_accept;
    logic [31:0] new_word;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (seq_reg == SEQ_IDLE) && out_free;
    assign s_accept = s_valid && s_ready;
    assign new_word = {asm_reg[23:0], s_rx_byte};

    always_comb begin
        magic_next    = magic_reg;
        phase_next    = phase_reg;
        seq_next      = seq_reg;
        byte_cnt_next = byte_cnt_reg;
        asm_next      = asm_reg;
        shift_next    = shift_reg;
        cnt_next      = cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        res_next      = res_reg;

        if (cfg_wr_en) begin
            magic_next = cfg_wr_data;
        end

        if (s_accept) begin
            if (s_req_type == REQ_TICK) begin
                if (phase_reg == PH_CAL) begin
                    m_valid_next = 1'b1;
                    res_next = make_res(ACT_PULSE, 1'b0, 4'd0, 4'd0, STAT_OK, s_ready_level);
                    if (!s_ready_level) begin
                        // A low sample gives a second low pulse, issued by the sequencer.
                        phase_next = PH_IDLE;
                        seq_next   = SEQ_SHIFT;
                        cnt_next   = CNT_W'(1);
                        shift_next = '0;
                    end
                end
            end else begin
                unique case (phase_reg)
                    PH_CMD: begin
                        if (s_rx_byte == CMD_LOAD) begin
                            phase_next    = PH_DATA;
                            byte_cnt_next = 2'd0;
                            asm_next      = '0;
                        end else if (s_rx_byte == CMD_PIN) begin
                            phase_next = PH_IO;
                        end else if (s_rx_byte == CMD_CAL) begin
                            phase_next   = PH_CAL;
                            m_valid_next = 1'b1;
                            res_next = make_res(ACT_STATUS, 1'b0, 4'd0, 4'd0, STAT_CAL, 1'b1);
                        end else begin
                            phase_next   = PH_IDLE;
                            m_valid_next = 1'b1;
                            res_next = make_res(ACT_STATUS, 1'b0, 4'd0, 4'd0,
                                                STAT_BAD_CMD, 1'b1);
                        end
                    end
                    PH_DATA: begin
                        asm_next = new_word;
                        if (byte_cnt_reg == LAST_BYTE) begin
                            byte_cnt_next = 2'd0;
                            phase_next    = PH_IDLE;
                            m_valid_next  = 1'b1;
                            res_next = make_res(ACT_PULSE, new_word[SHIFT_BITS-1], 4'd0, 4'd0,
                                                STAT_OK, 1'(SHIFT_BITS == 1));
                            if (SHIFT_BITS > 1) begin
                                seq_next   = SEQ_SHIFT;
                                cnt_next   = CNT_W'(SHIFT_BITS - 1);
                                shift_next = new_word[SHIFT_BITS-1:0] << 1;
                            end
                        end else begin
                            byte_cnt_next = byte_cnt_reg + 2'd1;
                        end
                    end
                    PH_IO: begin
                        phase_next   = PH_IDLE;
                        m_valid_next = 1'b1;
                        res_next = make_res(ACT_PIN, 1'b0, s_rx_byte[7:4], s_rx_byte[3:0],
                                            STAT_OK, 1'b1);
                    end
                    PH_CAL: begin
                        // Bytes received during calibration are dropped.
                    end
                    default: begin
                        if (s_rx_byte == magic_reg) begin
                            phase_next = PH_CMD;
                        end else begin
                            phase_next   = PH_IDLE;
                            m_valid_next = 1'b1;
                            res_next = make_res(ACT_STATUS, 1'b0, 4'd0, 4'd0,
                                                STAT_BAD_MAG, 1'b1);
                        end
                    end
                endcase
            end
        end else if (seq_reg == SEQ_SHIFT && out_free) begin
            m_valid_next = 1'b1;
            res_next = make_res(ACT_PULSE, shift_reg[SHIFT_BITS-1], 4'd0, 4'd0, STAT_OK,
                                cnt_reg == CNT_W'(1));
            shift_next = shift_reg << 1;
            cnt_next   = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                seq_next = SEQ_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_reg    <= MAGIC_RESET;
            phase_reg    <= PH_IDLE;
            seq_reg      <= SEQ_IDLE;
            byte_cnt_reg <= 2'd0;
            asm_reg      <= '0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            magic_reg    <= magic_next;
            phase_reg    <= phase_next;
            seq_reg      <= seq_next;
            byte_cnt_reg <= byte_cnt_next;
            asm_reg      <= asm_next;
            cnt_reg      <= cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        res_reg   <= res_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_action     = res_reg.action;
    assign m_data_bit   = res_reg.data_bit;
    assign m_pin_number = res_reg.pin_number;
    assign m_pin_value  = res_reg.pin_value;
    assign m_status     = res_reg.status;
    assign m_last       = res_reg.last;

`ifndef ASSERT_OFF
    a_shift_count_live: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_reg == SEQ_SHIFT |-> cnt_reg != '0)
        else $error("shift sequencer active with no pulses left");

    a_shift_parser_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_reg == SEQ_SHIFT |-> phase_reg == PH_IDLE)
        else $error("parser not idle while pulses are being issued");

    a_cal_high_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_req_type == REQ_TICK && s_ready_level && phase_reg == PH_CAL
        |=> m_valid && m_last && m_action == ACT_PULSE)
        else $error("high calibration tick did not give a final pulse");
`endif

endmodule

// ----- tb/sv/ucsl_checker.sv -----
// Checker for the UART command shift loader: frame predictor and result comparison.
`timescale 1ns / 100ps
module ucsl_checker
    import ucsl_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic       s_req_type,
    input  logic [7:0] s_rx_byte,
    input  logic       s_ready_level,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [1:0] m_action,
    input  logic       m_data_bit,
    input  logic [3:0] m_pin_number,
    input  logic [3:0] m_pin_value,
    input  logic [1:0] m_status,
    input  logic       m_last,
    output int         mismatch_count,
    output int         outstanding,
    output int         items_accepted,
    output int         results_checked
);

    localparam int MAX_REPORTS = 10;

    phase_t      frame_phase;
    logic [1:0]  data_bytes;
    logic [31:0] load_word;
    logic [7:0]  magic_byte;
    res_t        expected_actions[$];
    res_t        seen;

    assign seen = {m_action, m_data_bit, m_pin_number, m_pin_value, m_status, m_last};

    task automatic push_action(input logic [1:0] act, input logic dbit,
                               input logic [3:0] pin, input logic [3:0] val,
                               input logic [1:0] st, input logic lst);
        res_t r;
        r.action     = act;
        r.data_bit   = dbit;
        r.pin_number = pin;
        r.pin_value  = val;
        r.status     = st;
        r.last       = lst;
        expected_actions.push_back(r);
    endtask

    // Advances the frame parser by one transaction and queues the actions it causes.
    task automatic decode_item(input logic req, input logic [7:0] b, input logic lvl);
        int i;
        if (req == REQ_TICK) begin
            // Ready ticks only matter while calibrating.
            if (frame_phase == PH_CAL) begin
                if (lvl) begin
                    push_action(ACT_PULSE, 1'b0, 4'd0, 4'd0, STAT_OK, 1'b1);
                end else begin
                    push_action(ACT_PULSE, 1'b0, 4'd0, 4'd0, STAT_OK, 1'b0);
                    push_action(ACT_PULSE, 1'b0, 4'd0, 4'd0, STAT_OK, 1'b1);
                    frame_phase = PH_IDLE;
                end
            end
        end else begin
            case (frame_phase)
                PH_CMD: begin
                    if (b == CMD_LOAD) begin
                        frame_phase = PH_DATA;
                        data_bytes  = '0;
                        load_word   = '0;
                    end else if (b == CMD_PIN) begin
                        frame_phase = PH_IO;
                    end else if (b == CMD_CAL) begin
                        frame_phase = PH_CAL;
                        push_action(ACT_STATUS, 1'b0, 4'd0, 4'd0, STAT_CAL, 1'b1);
                    end else begin
                        frame_phase = PH_IDLE;
                        push_action(ACT_STATUS, 1'b0, 4'd0, 4'd0, STAT_BAD_CMD, 1'b1);
                    end
                end
                PH_DATA: begin
                    load_word = {load_word[23:0], b};
                    if (data_bytes == LAST_BYTE) begin
                        data_bytes  = '0;
                        frame_phase = PH_IDLE;
                        for (i = 0; i < SHIFT_BITS; i++) begin
                            push_action(ACT_PULSE, load_word[SHIFT_BITS - 1 - i], 4'd0, 4'd0,
                                        STAT_OK, i == SHIFT_BITS - 1);
                        end
                    end else begin
                        data_bytes = data_bytes + 2'd1;
                    end
                end
                PH_IO: begin
                    push_action(ACT_PIN, 1'b0, b[7:4], b[3:0], STAT_OK, 1'b1);
                    frame_phase = PH_IDLE;
                end
                PH_CAL: begin
                    // Bytes are dropped while calibrating.
                end
                default: begin
                    if (b == magic_byte) begin
                        frame_phase = PH_CMD;
                    end else begin
                        frame_phase = PH_IDLE;
                        push_action(ACT_STATUS, 1'b0, 4'd0, 4'd0, STAT_BAD_MAG, 1'b1);
                    end
                end
            endcase
        end
    endtask

    task automatic check_action(input res_t got);
        res_t want;
        results_checked++;
        if (expected_actions.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
                $display("%0t: unexpected result act=%0d bit=%0d pin=%0d val=%0d st=%0d last=%0d",
                         $realtime, got.action, got.data_bit, got.pin_number,
                         got.pin_value, got.status, got.last);
            end
        end else begin
            want = expected_actions.pop_front();
            if (got.action !== want.action || got.data_bit !== want.data_bit ||
                got.pin_number !== want.pin_number || got.pin_value !== want.pin_value ||
                got.status !== want.status || got.last !== want.last) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("%0t: mismatch expected act=%0d bit=%0d pin=%0d val=%0d st=%0d last=%0d",
                             $realtime, want.action, want.data_bit, want.pin_number,
                             want.pin_value, want.status, want.last);
                    $display("%0t:          actual   act=%0d bit=%0d pin=%0d val=%0d st=%0d last=%0d",
                             $realtime, got.action, got.data_bit, got.pin_number,
                             got.pin_value, got.status, got.last);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            frame_phase = PH_IDLE;
            data_bytes  = '0;
            load_word   = '0;
            magic_byte  = MAGIC_RESET;
            expected_actions.delete();
        end else begin
            // Results are popped first, as they always belong to older transactions.
            if (m_valid && m_ready) begin
                check_action(seen);
            end
            if (s_valid && s_ready) begin
                items_accepted++;
                decode_item(s_req_type, s_rx_byte, s_ready_level);
            end
            if (cfg_wr_en) begin
                magic_byte = cfg_wr_data;
            end
        end
        outstanding <= expected_actions.size();
    end

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench top: clock, reset, stimulus, idling and verdict for the shift loader core.
`timescale 1ns / 100ps
module tb_top;
    import ucsl_pkg::*;

    // Enough cycles for any transaction still in flight, a load being the longest.
    localparam int SETTLE_CYCLES = 40;

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       cfg_wr_en     = 1'b0;
    logic [7:0] cfg_wr_data   = 8'd0;
    logic       s_valid       = 1'b0;
    logic       s_req_type    = 1'b0;
    logic [7:0] s_rx_byte     = 8'd0;
    logic       s_ready_level = 1'b0;
    logic       m_ready       = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [1:0] m_action;
    logic       m_data_bit;
    logic [3:0] m_pin_number;
    logic [3:0] m_pin_value;
    logic [1:0] m_status;
    logic       m_last;

    int         send_idle_pct = 9;
    int         recv_idle_pct = 66;
    int         stim_items    = 0;
    int         settings_used = 0;
    logic [7:0] cur_magic     = MAGIC_RESET;

    int mismatch_count;
    int outstanding;
    int items_accepted;
    int results_checked;

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    uart_command_shift_loader_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_rx_byte     (s_rx_byte),
        .s_ready_level (s_ready_level),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_action      (m_action),
        .m_data_bit    (m_data_bit),
        .m_pin_number  (m_pin_number),
        .m_pin_value   (m_pin_value),
        .m_status      (m_status),
        .m_last        (m_last)
    );

    ucsl_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_rx_byte       (s_rx_byte),
        .s_ready_level   (s_ready_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_action        (m_action),
        .m_data_bit      (m_data_bit),
        .m_pin_number    (m_pin_number),
        .m_pin_value     (m_pin_value),
        .m_status        (m_status),
        .m_last          (m_last),
        .mismatch_count  (mismatch_count),
        .outstanding     (outstanding),
        .items_accepted  (items_accepted),
        .results_checked (results_checked)
    );

    // Valid is only lowered during a gap, so back-to-back transactions keep it high.
    task automatic send_item(input logic rt, input logic [7:0] b, input logic lvl);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_req_type    <= rt;
        s_rx_byte     <= b;
        s_ready_level <= lvl;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(REQ_BYTE, b, 1'($urandom_range(1)));
    endtask

    task automatic send_tick(input logic lvl);
        send_item(REQ_TICK, 8'($urandom_range(255)), lvl);
    endtask

    task automatic drain_and_settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_magic(input logic [7:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_magic = v;
        settings_used++;
    endtask

    // Mostly well-formed frames with random content, plus stray and broken input.
    task automatic send_random_frame();
        int         kind;
        int         n;
        int         k;
        logic [7:0] b;
        kind = $urandom_range(99);
        if (kind < 25) begin
            send_byte(cur_magic);
            send_byte(CMD_LOAD);
            for (k = 0; k < 4; k++) send_byte(8'($urandom_range(255)));
            stim_items += 6;
        end else if (kind < 45) begin
            send_byte(cur_magic);
            send_byte(CMD_PIN);
            send_byte(8'($urandom_range(255)));
            stim_items += 3;
        end else if (kind < 60) begin
            send_byte(cur_magic);
            send_byte(CMD_CAL);
            n = $urandom_range(4);
            for (k = 0; k < n; k++) begin
                // Bytes sent while calibrating should vanish without a result.
                if ($urandom_range(3) == 0) send_byte(8'($urandom_range(255)));
                send_tick(1'b1);
            end
            send_tick(1'b0);
            stim_items += 3 + n;
        end else if (kind < 70) begin
            b = 8'($urandom_range(255));
            while (b >= CMD_LOAD && b <= CMD_CAL) b = 8'($urandom_range(255));
            send_byte(cur_magic);
            send_byte(b);
            stim_items += 2;
        end else if (kind < 85) begin
            k = $urandom_range(3);
            if (k == 0) begin
                send_tick(1'($urandom_range(1)));
            end else if (k == 1) begin
                send_byte(cur_magic);
                stim_items++;
            end else begin
                send_byte(8'($urandom_range(255)));
                stim_items++;
            end
        end else begin
            // A load cut short leaves the parser collecting, so later frames realign.
            send_byte(cur_magic);
            if ($urandom_range(1)) begin
                send_byte(CMD_LOAD);
                n = $urandom_range(3);
                for (k = 0; k < n; k++) send_byte(8'($urandom_range(255)));
                stim_items += 2 + n;
            end else begin
                send_tick(1'($urandom_range(1)));
                stim_items++;
            end
        end
    endtask

    task automatic run_random(input int count);
        int goal;
        goal = stim_items + count;
        while (stim_items < goal) send_random_frame();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part with the reset magic byte.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_tick(1'b1);
        send_tick(1'b0);
        send_byte(cur_magic);
        send_byte(CMD_LOAD);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(cur_magic);
        send_byte(CMD_PIN);
        send_byte(8'hF0);
        send_byte(cur_magic);
        send_byte(CMD_PIN);
        send_byte(8'h0F);
        send_byte(cur_magic);
        send_byte(CMD_CAL);
        send_byte(8'h55);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_byte(cur_magic);
        send_byte(8'h00);
        send_byte(cur_magic);
        send_byte(8'hFF);

        drain_and_settle();
        write_magic(8'h00);
        run_random(170);

        drain_and_settle();
        send_idle_pct = 66;
        recv_idle_pct = 9;
        write_magic(8'hFF);
        run_random(170);

        drain_and_settle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_magic(8'($urandom_range(255)));
        run_random(100);

        drain_and_settle();
        write_magic(MAGIC_RESET);
        run_random(60);

        drain_and_settle();
        $display("Covered %0d accepted transactions and %0d checked results over %0d magic values.",
                 items_accepted, results_checked, settings_used);
        $display("Loads, pin writes, calibration, bad frames and stray ticks ran under three idling mixes.");
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timeout with %0d results still outstanding.", outstanding);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/ucsl_pkg.sv
rtl/uart_command_shift_loader_core.sv
tb/sv/ucsl_checker.sv
tb/sv/tb_top.sv
